### rtl/ssks_pkg.sv
// Package for the summed-key stable sorter: widths, codes and shared types.
// Depends on nothing; used by the interfaces and every module.
package ssks_pkg;
  localparam int MaxOrders = 1024;
  localparam int TimeBits  = 20;
  localparam int KeyBits   = TimeBits + 1;
  localparam int AddrBits  = $clog2(MaxOrders);
  localparam int CountBits = AddrBits + 1;
  localparam int NumBits   = CountBits;
  localparam int StatBits  = 2;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModePop    = 1'b1;

  localparam logic [StatBits-1:0] StatOk    = 2'd0;
  localparam logic [StatBits-1:0] StatEmpty = 2'd1;
  localparam logic [StatBits-1:0] StatFull  = 2'd2;

  // one stored entry of the heap
  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [NumBits-1:0] num;
  } entry_t;

  typedef struct packed {
    logic               mode;
    logic [TimeBits-1:0] first_time;
    logic [TimeBits-1:0] second_time;
  } in_item_t;

  typedef struct packed {
    logic [NumBits-1:0]  order_number;
    logic [StatBits-1:0] status;
    logic                last_one;
  } out_item_t;

  // heap ordering: a before b on smaller key, then earlier number
  function automatic logic ent_less(entry_t a, entry_t b);
    ent_less = (a.key < b.key) || ((a.key == b.key) && (a.num < b.num));
  endfunction
endpackage

### rtl/ssks_in_if.sv
// Input channel for the sorter: valid/ready handshake with insert or pop item.
// Depends on ssks_pkg.
interface ssks_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [ssks_pkg::TimeBits-1:0]  first_time;
  logic [ssks_pkg::TimeBits-1:0]  second_time;
  modport source (output valid, mode, first_time, second_time, input ready);
  modport sink   (input valid, mode, first_time, second_time, output ready);
endinterface

### rtl/ssks_out_if.sv
// Result channel for the sorter: valid/ready handshake with one result item.
// Depends on ssks_pkg.
interface ssks_out_if;
  logic                           valid;
  logic                           ready;
  logic [ssks_pkg::NumBits-1:0]   order_number;
  logic [ssks_pkg::StatBits-1:0]  status;
  logic                           last_one;
  modport source (output valid, order_number, status, last_one, input ready);
  modport sink   (input valid, order_number, status, last_one, output ready);
endinterface

### rtl/stable_sum_key_sorter_core.sv
// Top level of the summed-key stable sorter: heap sequencer around one RAM.
// Depends on ssks_pkg, ssks_in_if, ssks_out_if and ssks_heap_ram.
//
// Orders are held in a binary min-heap in one RAM, ordered by (key, order number),
// so equal keys leave in insertion order. An item is taken only while the
// sequencer is idle and the previous result has left or leaves in that cycle.
// A dropped insert or a pop of an empty store answers in the cycle after the
// accept. An insert walks upwards from the new leaf level by level (parent
// read, compare); a pop reads the root and the last leaf, then walks downwards
// level by level (right child read, compare), which may end with one final leaf
// write. Results wait in an output register until taken. Entries beyond the
// held count may be read but are never used, so no clearing pass is needed.
module stable_sum_key_sorter_core (
  input logic        clk_i,
  input logic        rst_ni,
  ssks_in_if.sink    in_if,
  ssks_out_if.source out_if
);
  localparam int AB = ssks_pkg::AddrBits;
  localparam int CB = ssks_pkg::CountBits;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StUpRd  = 3'd1;
  localparam logic [2:0] StUpCmp = 3'd2;
  localparam logic [2:0] StDnRd  = 3'd3;
  localparam logic [2:0] StDnR2  = 3'd4;
  localparam logic [2:0] StDnCmp = 3'd5;
  localparam logic [2:0] StRoot  = 3'd6;
  localparam logic [2:0] StDnWr  = 3'd7;

  logic [2:0]               st_q, st_d;
  logic [CB-1:0]            held_q, held_d;
  logic [ssks_pkg::NumBits-1:0] taken_q, taken_d;
  logic [AB-1:0]            pos_q, pos_d;
  ssks_pkg::entry_t         cur_q, cur_d;   // entry being sifted
  ssks_pkg::entry_t         lch_q, lch_d;   // left child latched
  logic                     ovld_q, ovld_d;
  ssks_pkg::out_item_t      out_q, out_d;

  logic                     we;
  logic [AB-1:0]            waddr, raddr;
  ssks_pkg::entry_t         wdata, rdata;

  ssks_heap_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic             in_fire;
  logic [CB:0]      lidx, ridx;
  logic [AB-1:0]    parent;
  logic             rgt_sel;
  ssks_pkg::entry_t sel_ent;
  logic [CB:0]      sel_idx;
  logic [CB+1:0]    nl_idx;

  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (st_q == StIdle) && (!ovld_q || out_if.ready);
  assign lidx   = {1'b0, pos_q, 1'b0} + (CB+1)'(1);
  assign ridx   = lidx + (CB+1)'(1);
  assign parent = AB'(({1'b0, pos_q} - (CB)'(1)) >> 1);

  // smaller of the two children; the right one only where it is held
  assign rgt_sel = (ridx < (CB+1)'(held_q)) && ssks_pkg::ent_less(rdata, lch_q);
  assign sel_ent = rgt_sel ? rdata : lch_q;
  assign sel_idx = rgt_sel ? ridx : lidx;
  assign nl_idx  = {sel_idx, 1'b0} + (CB+2)'(1);

  // sequencer
  always_comb begin
    st_d = st_q; held_d = held_q; taken_d = taken_q; pos_d = pos_q;
    cur_d = cur_q; lch_d = lch_q; ovld_d = ovld_q; out_d = out_q;
    we = 1'b0; waddr = pos_q; wdata = cur_q; raddr = parent;
    if (out_if.valid && out_if.ready) ovld_d = 1'b0;
    case (st_q)
      StIdle: begin
        raddr = '0;
        if (in_fire) begin
          ovld_d = 1'b1;
          out_d = '{order_number: '0, status: ssks_pkg::StatOk, last_one: 1'b0};
          if (in_if.mode == ssks_pkg::ModeInsert) begin
            if (32'(taken_q) >= ssks_pkg::MaxOrders) begin
              out_d.status = ssks_pkg::StatFull;
            end else begin
              taken_d = taken_q + 1'b1;
              cur_d.key = ssks_pkg::KeyBits'(in_if.first_time)
                        + ssks_pkg::KeyBits'(in_if.second_time);
              cur_d.num = taken_q + 1'b1;
              pos_d  = AB'(held_q);
              held_d = held_q + 1'b1;
              st_d   = StUpRd;
            end
          end else if (held_q == '0) begin
            out_d.status = ssks_pkg::StatEmpty;
          end else begin
            held_d = held_q - 1'b1;
            out_d.last_one = (held_q == CB'(1));
            // root read in this cycle; last leaf read next
            st_d = StRoot;
          end
        end
      end
      StUpRd: begin
        // parent read issued
        if (pos_q == '0) begin
          we = 1'b1; st_d = StIdle;
        end else st_d = StUpCmp;
      end
      StUpCmp: begin
        if (ssks_pkg::ent_less(cur_q, rdata)) begin
          we = 1'b1; wdata = rdata; pos_d = parent; st_d = StUpRd;
        end else begin
          we = 1'b1; st_d = StIdle;
        end
      end
      StRoot: begin
        // rdata is root; fetch last leaf
        out_d.order_number = rdata.num;
        raddr = AB'(held_q);
        pos_d = '0;
        st_d = (held_q == '0) ? StIdle : StDnRd;
      end
      StDnRd: begin
        cur_d = rdata;
        raddr = AB'(lidx);
        st_d = (lidx < (CB+1)'(held_q)) ? StDnR2 : StIdle;
        if (lidx >= (CB+1)'(held_q)) begin
          we = 1'b1; wdata = rdata;
        end
      end
      StDnR2: begin
        lch_d = rdata;
        raddr = AB'(ridx);
        st_d = StDnCmp;
      end
      StDnCmp: begin
        if (ssks_pkg::ent_less(sel_ent, cur_q)) begin
          // move the child up, go on below it or finish with a leaf write
          we = 1'b1; wdata = sel_ent; pos_d = AB'(sel_idx);
          raddr = AB'(nl_idx);
          st_d = (nl_idx < (CB+2)'(held_q)) ? StDnR2 : StDnWr;
        end else begin
          we = 1'b1; st_d = StIdle;
        end
      end
      StDnWr: begin
        we = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; held_q <= '0; taken_q <= '0; ovld_q <= 1'b0;
    end else begin
      st_q <= st_d; held_q <= held_d; taken_q <= taken_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; cur_q <= cur_d; lch_q <= lch_d; out_q <= out_d;
  end

  assign out_if.valid        = ovld_q && (st_q == StIdle);
  assign out_if.order_number = out_q.order_number;
  assign out_if.status       = out_q.status;
  assign out_if.last_one     = out_q.last_one;
endmodule

### rtl/ssks_heap_ram.sv
// Single-port-write, one-read synchronous RAM holding heap entries.
// Depends on ssks_pkg.
module ssks_heap_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ssks_pkg::AddrBits-1:0] waddr_i,
  input  ssks_pkg::entry_t              wdata_i,
  input  logic [ssks_pkg::AddrBits-1:0] raddr_i,
  output ssks_pkg::entry_t              rdata_o
);
  ssks_pkg::entry_t mem_q [ssks_pkg::MaxOrders];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
